@@ hdl/elrs_pkg.sv @@
// shared types and constants of the event log ring store
package elrs_pkg;

  localparam int RECORDS = 128;
  localparam int SLOTS   = RECORDS + 1;
  localparam int IDX_W   = $clog2(SLOTS);
  localparam int CNT_W   = IDX_W + 1;

  localparam logic [15:0] ID_FIRST     = 16'h0000;
  localparam logic [15:0] ID_LAST      = 16'hFFFF;
  localparam logic [15:0] RSV_MAX      = 16'hFFFE;
  localparam logic [15:0] RSV_FIRST    = 16'h0001;
  localparam logic [7:0]  TYPE_OEM_MIN = 8'hE0;

  typedef enum logic [1:0] {
    REQ_ADD     = 2'd0,
    REQ_GET     = 2'd1,
    REQ_RESERVE = 2'd2,
    REQ_ERASE   = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_EMPTY        = 2'd1,
    ST_BAD_ID       = 2'd2,
    ST_RSV_MISMATCH = 2'd3
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } ctrl_state_e;

  typedef struct packed {
    req_type_e   req_type;
    logic [15:0] record_id_in;
    logic [15:0] reservation_in;
    logic [63:0] record_low;
    logic [63:0] record_high;
    logic [31:0] now_time;
  } in_word_t;

  typedef struct packed {
    status_e     status;
    logic [15:0] record_id_out;
    logic [15:0] next_record_id;
    logic [63:0] entry_low;
    logic [63:0] entry_high;
    logic [7:0]  entry_count;
    logic [15:0] reservation_out;
    logic [31:0] last_add_time;
    logic [31:0] last_erase_time;
  } out_word_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic capture;
    logic commit;
  } ctrl_cmd_t;

endpackage

@@ hdl/elrs_ctrl.sv @@
// controller state machine: sequences capture and commit, owns output valid
module elrs_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output elrs_pkg::ctrl_cmd_t cmd_o
);
  import elrs_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;

  assign out_free = !out_valid_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs and commands
  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      S_EXEC: begin
        cmd_o.commit = out_free;
        if (out_free) out_valid_d = 1'b1;
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

@@ hdl/elrs_datapath.sv @@
// datapath: record store, ring pointers, reservation, stamps and result register
module elrs_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  elrs_pkg::ctrl_cmd_t cmd_i,
  input  elrs_pkg::in_word_t  in_data_i,
  output elrs_pkg::out_word_t out_data_o
);
  import elrs_pkg::*;

  // record store, no reset
  logic [63:0] low_mem  [SLOTS];
  logic [63:0] high_mem [SLOTS];

  logic [IDX_W-1:0] head_q, head_d, tail_q, tail_d;
  logic [15:0]      rsv_q, rsv_d;
  logic [31:0]      add_stamp_q, add_stamp_d, erase_stamp_q, erase_stamp_d;

  // captured request
  req_type_e   req_q;
  logic [15:0] slot_q, rsv_in_q;
  logic [63:0] lo_q, hi_q;
  logic [31:0] now_q;
  logic [63:0] rd_lo_q, rd_hi_q;
  out_word_t   out_q, out_d;

  logic [15:0]      slot_sel;
  logic [IDX_W-1:0] rd_addr;
  logic [CNT_W-1:0] cnt_cur, cnt_new;
  logic [IDX_W-1:0] slot_idx, nxt_slot;
  logic [15:0]      add_id;
  logic [63:0]      add_lo;
  logic             wr_en;

  function automatic logic [IDX_W-1:0] wrap_next(input logic [IDX_W-1:0] s);
    return (s >= IDX_W'(RECORDS)) ? '0 : s + 1'b1;
  endfunction

  function automatic logic [CNT_W-1:0] occupancy(input logic [IDX_W-1:0] h,
                                                  input logic [IDX_W-1:0] t);
    if (h <= t) return {1'b0, t} - {1'b0, h};
    return {1'b0, t} + CNT_W'(SLOTS) - {1'b0, h};
  endfunction

  // slot lookup for a get, from the incoming word
  always_comb begin
    priority if (in_data_i.record_id_in == ID_FIRST) begin
      slot_sel = 16'(head_q);
    end else if (in_data_i.record_id_in == ID_LAST) begin
      slot_sel = (tail_q == '0) ? 16'(RECORDS) : 16'(tail_q) - 16'd1;
    end else begin
      slot_sel = in_data_i.record_id_in - 16'd1;
    end
    rd_addr = (slot_sel <= 16'(RECORDS)) ? slot_sel[IDX_W-1:0] : '0;
  end

  // capture the request and read the addressed slot
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q    <= in_data_i.req_type;
      slot_q   <= slot_sel;
      rsv_in_q <= in_data_i.reservation_in;
      lo_q     <= in_data_i.record_low;
      hi_q     <= in_data_i.record_high;
      now_q    <= in_data_i.now_time;
      rd_lo_q  <= low_mem[rd_addr];
      rd_hi_q  <= high_mem[rd_addr];
    end
  end

  // record store write port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      low_mem[tail_q]  <= add_lo;
      high_mem[tail_q] <= hi_q;
    end
  end

  // id and timestamp patch of an added record
  always_comb begin
    add_id = 16'(tail_q) + 16'd1;
    add_lo = {lo_q[63:16], add_id};
    if (add_lo[23:16] < TYPE_OEM_MIN) add_lo[55:24] = now_q;
  end

  assign cnt_cur  = occupancy(head_q, tail_q);
  assign slot_idx = slot_q[IDX_W-1:0];
  assign nxt_slot = wrap_next(slot_idx);

  // request execution
  always_comb begin
    head_d        = head_q;
    tail_d        = tail_q;
    rsv_d         = rsv_q;
    add_stamp_d   = add_stamp_q;
    erase_stamp_d = erase_stamp_q;
    wr_en         = 1'b0;
    out_d         = '0;
    out_d.status  = ST_OK;
    unique case (req_q)
      REQ_ADD: begin
        if (cnt_cur == CNT_W'(RECORDS)) head_d = wrap_next(head_q);
        wr_en               = cmd_i.commit;
        tail_d              = wrap_next(tail_q);
        add_stamp_d         = now_q;
        out_d.record_id_out = add_id;
        out_d.entry_low     = add_lo;
        out_d.entry_high    = hi_q;
      end
      REQ_GET: begin
        priority if (cnt_cur == '0) begin
          out_d.status = ST_EMPTY;
        end else if (slot_q > 16'(RECORDS)) begin
          out_d.status = ST_BAD_ID;
        end else if (head_q < tail_q && (slot_idx < head_q || slot_idx >= tail_q)) begin
          out_d.status = ST_BAD_ID;
        end else if (head_q > tail_q && slot_idx >= tail_q && slot_idx < head_q) begin
          out_d.status = ST_BAD_ID;
        end else begin
          out_d.entry_low      = rd_lo_q;
          out_d.entry_high     = rd_hi_q;
          out_d.next_record_id = (nxt_slot == tail_q) ? ID_LAST : 16'(nxt_slot) + 16'd1;
        end
      end
      REQ_RESERVE: begin
        rsv_d = (rsv_q == RSV_MAX) ? RSV_FIRST : rsv_q + 16'd1;
      end
      REQ_ERASE: begin
        if (rsv_in_q != rsv_q) begin
          out_d.status = ST_RSV_MISMATCH;
        end else begin
          head_d        = '0;
          tail_d        = '0;
          erase_stamp_d = now_q;
        end
      end
      default: ;
    endcase
    cnt_new               = occupancy(head_d, tail_d);
    out_d.entry_count     = 8'(cnt_new);
    out_d.reservation_out = rsv_d;
    out_d.last_add_time   = add_stamp_d;
    out_d.last_erase_time = erase_stamp_d;
  end

  // log state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q        <= '0;
      tail_q        <= '0;
      rsv_q         <= RSV_FIRST;
      add_stamp_q   <= '0;
      erase_stamp_q <= '0;
    end else if (cmd_i.commit) begin
      head_q        <= head_d;
      tail_q        <= tail_d;
      rsv_q         <= rsv_d;
      add_stamp_q   <= add_stamp_d;
      erase_stamp_q <= erase_stamp_d;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) out_q <= out_d;
  end

  assign out_data_o = out_q;

endmodule

@@ hdl/event_log_ring_store.sv @@
// top level of the event log ring store
//
//   channel | valid       | ready       | word
//   --------+-------------+-------------+------------
//   request | in_valid_i  | in_ready_o  | in_data_i
//   result  | out_valid_o | out_ready_i | out_data_o
//
// each request is accepted with the slot read, then executes and loads
// the result register
// reset clears pointers and stamps, sets reservation to 1; store is not cleared
// a stalled result holds the block in execute until the result register frees
// a new request is taken while the previous result still waits
module event_log_ring_store (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  elrs_pkg::in_word_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output elrs_pkg::out_word_t out_data_o
);
  import elrs_pkg::*;

  ctrl_cmd_t cmd;

  // sequencer
  elrs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // store and request logic
  elrs_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_data_i  (in_data_i),
    .out_data_o (out_data_o)
  );

endmodule

@@ hdl/elrs_checker.sv @@
// port-level checks of the event log ring store and their bind
module elrs_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input elrs_pkg::out_word_t out_data_i
);
  import elrs_pkg::*;

  // an accepted word keeps the block busy for the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("request taken back to back");

  // a result appears only at the end of execute, after which input opens
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> in_ready_i && $past(!in_ready_i))
    else $error("result appeared outside execute");

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("stalled result changed");

  // count and reservation stay in range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_data_i.entry_count <= 8'(RECORDS) &&
                    out_data_i.reservation_out != 16'h0000 &&
                    out_data_i.reservation_out != ID_LAST)
    else $error("result field out of range");

endmodule

bind event_log_ring_store elrs_checker u_elrs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_i  (in_ready_o),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_i  (out_data_o)
);

@@ sim/elrs_log_checker.sv @@
`timescale 1ns / 100ps
// checker for the event log ring store: watches both channels, predicts and compares each word
module elrs_log_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  elrs_pkg::in_word_t  in_data_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  elrs_pkg::out_word_t out_data_i,
  output int                  mismatches_o,
  output int                  awaited_o,
  output int                  compared_o
);
  import elrs_pkg::*;

  // predicted log contents and bookkeeping
  logic [63:0] low_words [SLOTS];
  logic [63:0] high_words [SLOTS];
  int unsigned log_head;
  int unsigned log_tail;
  logic [15:0] rsv_cur;
  logic [31:0] add_stamp_v;
  logic [31:0] erase_stamp_v;

  out_word_t expected_responses [$];
  out_word_t want;
  int        mismatches = 0;
  int        compared = 0;

  assign mismatches_o = mismatches;
  assign compared_o   = compared;

  function automatic int unsigned slot_after(int unsigned s);
    return (s >= RECORDS) ? 0 : s + 1;
  endfunction

  function automatic int unsigned stored_count();
    return (log_head <= log_tail) ? log_tail - log_head : log_tail + SLOTS - log_head;
  endfunction

  // response of the log to one request word, updating the predicted state
  function automatic out_word_t serve_request(in_word_t w);
    out_word_t   r;
    logic [63:0] lo;
    int unsigned slot;
    int unsigned nxt;
    logic        bad;
    r = '0;
    r.status = ST_OK;
    case (w.req_type)
      REQ_ADD: begin
        // full log drops its oldest record
        if (stored_count() == RECORDS) log_head = slot_after(log_head);
        lo = w.record_low;
        lo[15:0] = 16'(log_tail + 1);
        // system records get the current time stamped in
        if (lo[23:16] < TYPE_OEM_MIN) lo[55:24] = w.now_time;
        low_words[log_tail]  = lo;
        high_words[log_tail] = w.record_high;
        r.record_id_out = lo[15:0];
        r.entry_low     = lo;
        r.entry_high    = w.record_high;
        log_tail    = slot_after(log_tail);
        add_stamp_v = w.now_time;
      end
      REQ_GET: begin
        if (w.record_id_in == ID_FIRST) slot = log_head;
        else if (w.record_id_in == ID_LAST) slot = (log_tail != 0) ? log_tail - 1 : RECORDS;
        else slot = w.record_id_in - 1;
        // slot must lie in the occupied region, which may wrap
        bad = (slot > RECORDS) ||
              (log_head < log_tail && (slot < log_head || slot >= log_tail)) ||
              (log_head > log_tail && slot >= log_tail && slot < log_head);
        if (stored_count() == 0) begin
          r.status = ST_EMPTY;
        end else if (bad) begin
          r.status = ST_BAD_ID;
        end else begin
          nxt = slot_after(slot);
          r.entry_low      = low_words[slot];
          r.entry_high     = high_words[slot];
          r.next_record_id = (nxt == log_tail) ? ID_LAST : 16'(nxt + 1);
        end
      end
      REQ_RESERVE: begin
        rsv_cur = (rsv_cur == RSV_MAX) ? RSV_FIRST : rsv_cur + 16'd1;
      end
      REQ_ERASE: begin
        if (w.reservation_in != rsv_cur) begin
          r.status = ST_RSV_MISMATCH;
        end else begin
          log_head      = 0;
          log_tail      = 0;
          erase_stamp_v = w.now_time;
        end
      end
    endcase
    r.entry_count     = 8'(stored_count());
    r.reservation_out = rsv_cur;
    r.last_add_time   = add_stamp_v;
    r.last_erase_time = erase_stamp_v;
    return r;
  endfunction

  task automatic report_mismatch(string what);
    if (mismatches < 40) $display("%0t ns mismatch: %s", $time, what);
    mismatches++;
  endtask

  task automatic check_field(string name, logic [63:0] got, logic [63:0] exp_val);
    if (got !== exp_val)
      report_mismatch($sformatf("result %0d %s got %0h expected %0h",
                                compared, name, got, exp_val));
  endtask

  // predict on each accepted request, compare on each accepted result
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      log_head      = 0;
      log_tail      = 0;
      rsv_cur       = RSV_FIRST;
      add_stamp_v   = '0;
      erase_stamp_v = '0;
      expected_responses.delete();
      awaited_o <= 0;
    end else begin
      if (in_valid_i && in_ready_i) expected_responses.push_back(serve_request(in_data_i));
      if (out_valid_i && out_ready_i) begin
        if (expected_responses.size() == 0) begin
          report_mismatch("result word with no request waiting");
        end else begin
          want = expected_responses.pop_front();
          check_field("status", out_data_i.status, want.status);
          check_field("record_id_out", out_data_i.record_id_out, want.record_id_out);
          check_field("next_record_id", out_data_i.next_record_id, want.next_record_id);
          check_field("entry_low", out_data_i.entry_low, want.entry_low);
          check_field("entry_high", out_data_i.entry_high, want.entry_high);
          check_field("entry_count", out_data_i.entry_count, want.entry_count);
          check_field("reservation_out", out_data_i.reservation_out, want.reservation_out);
          check_field("last_add_time", out_data_i.last_add_time, want.last_add_time);
          check_field("last_erase_time", out_data_i.last_erase_time, want.last_erase_time);
          compared++;
        end
      end
      awaited_o <= expected_responses.size();
    end
  end

endmodule

@@ sim/tb_event_log_ring_store.sv @@
`timescale 1ns / 100ps
// testbench top for the event log ring store: stimulus, idling and verdict
module tb_event_log_ring_store;
  import elrs_pkg::*;

  localparam int ITEMS     = 1700;
  localparam int PHASE_LEN = ITEMS / 5;

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      in_valid;
  logic      in_ready;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_word_t out_data;

  int          mismatches;
  int          awaited;
  int          compared;
  bit          idle_on = 1'b1;
  logic [15:0] rsv_now = RSV_FIRST;
  int          n_add = 0;
  int          n_get = 0;
  int          n_rsv = 0;
  int          n_erase = 0;

  always #1 clk_i = ~clk_i;

  event_log_ring_store i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  elrs_log_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .mismatches_o (mismatches),
    .awaited_o    (awaited),
    .compared_o   (compared)
  );

  // request word with every field random
  function automatic in_word_t noise_word(req_type_e kind);
    in_word_t w;
    w.req_type       = kind;
    w.record_id_in   = 16'($urandom);
    w.reservation_in = 16'($urandom);
    w.record_low     = {$urandom, $urandom};
    w.record_high    = {$urandom, $urandom};
    w.now_time       = $urandom;
    return w;
  endfunction

  // one request word, with an optional gap before it
  task automatic send_word(in_word_t w);
    if (idle_on && $urandom_range(0, 2) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk_i); while (!in_ready);
    case (w.req_type)
      REQ_ADD:     n_add++;
      REQ_GET:     n_get++;
      REQ_RESERVE: begin
        n_rsv++;
        rsv_now = (rsv_now == RSV_MAX) ? RSV_FIRST : rsv_now + 16'd1;
      end
      REQ_ERASE:   n_erase++;
    endcase
  endtask

  task automatic do_add(logic [7:0] kind, logic [63:0] lo, logic [63:0] hi, logic [31:0] now);
    in_word_t w;
    w = noise_word(REQ_ADD);
    w.record_low        = lo;
    w.record_low[23:16] = kind;
    w.record_high       = hi;
    w.now_time          = now;
    send_word(w);
  endtask

  task automatic random_add();
    logic [7:0] kind;
    kind = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(TYPE_OEM_MIN, 8'hFF)) : 8'($urandom);
    do_add(kind, {$urandom, $urandom}, {$urandom, $urandom}, $urandom);
  endtask

  task automatic do_get(logic [15:0] id);
    in_word_t w;
    w = noise_word(REQ_GET);
    w.record_id_in = id;
    send_word(w);
  endtask

  task automatic do_reserve();
    send_word(noise_word(REQ_RESERVE));
  endtask

  task automatic do_erase(logic [15:0] rsv, logic [31:0] now);
    in_word_t w;
    w = noise_word(REQ_ERASE);
    w.reservation_in = rsv;
    w.now_time       = now;
    send_word(w);
  endtask

  // sender holds off until every expected word is back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (awaited != 0) @(posedge clk_i);
  endtask

  // mostly adds and gets; erases rare except in the middle phase
  task automatic random_request(int phase);
    int          pick;
    int          erase_lim;
    int          m;
    logic [15:0] id;
    erase_lim = (phase == 2) ? 60 : 4;
    pick = $urandom_range(0, 999);
    if (pick < erase_lim) begin
      if ($urandom_range(0, 3) != 0) do_erase(rsv_now, $urandom);
      else do_erase(16'($urandom), $urandom);
    end else if (pick < erase_lim + 80) begin
      do_reserve();
    end else if (pick < 550) begin
      random_add();
    end else begin
      m = $urandom_range(0, 19);
      if (m < 5) id = ID_FIRST;
      else if (m < 8) id = ID_LAST;
      else if (m < 17) id = 16'($urandom_range(1, RECORDS + 1));
      else id = 16'($urandom);
      do_get(id);
    end
  endtask

  // result side stalls in bursts
  initial begin
    out_ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (idle_on && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 40)) @(posedge clk_i);
      end
    end
  end

  // main stimulus
  initial begin
    in_valid <= 1'b0;
    in_data  <= '0;
    rst_ni   <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty log, reservation checks, stamping threshold, id lookups
    do_get(ID_FIRST);
    do_get(ID_LAST);
    do_erase(16'h0000, 32'h0000_0000);
    do_erase(16'hFFFF, 32'h0000_0000);
    do_erase(rsv_now, 32'hFFFF_FFFF);
    do_add(8'h00, '0, '0, 32'h0000_0000);
    do_add(8'hFF, '1, '1, 32'hFFFF_FFFF);
    do_add(8'hDF, {$urandom, $urandom}, {$urandom, $urandom}, $urandom);
    do_add(TYPE_OEM_MIN, {$urandom, $urandom}, {$urandom, $urandom}, $urandom);
    do_get(ID_FIRST);
    do_get(ID_LAST);
    do_get(16'd2);
    do_get(16'd5);
    do_get(16'(RECORDS + 1));
    do_get(16'(RECORDS + 2));
    do_get(16'hFFFE);
    do_reserve();
    do_erase(RSV_FIRST, $urandom);
    do_erase(rsv_now, $urandom);
    do_get(ID_FIRST);
    do_add(8'($urandom), {$urandom, $urandom}, {$urandom, $urandom}, 32'h0000_0000);

    // reserves back to back, then erase under the newest id and reserve again
    idle_on = 1'b0;
    repeat (6) do_reserve();
    do_erase(rsv_now, $urandom);
    do_reserve();
    idle_on = 1'b1;
    drain_results();

    // random phases, the last one without idling
    for (int i = 0; i < ITEMS; i++) begin
      if (i > 0 && i % PHASE_LEN == 0) begin
        drain_results();
        if (i / PHASE_LEN == 2) begin
          // fill past capacity so tail wraps to slot zero
          do_erase(rsv_now, $urandom);
          repeat (RECORDS + 1) random_add();
          do_get(ID_LAST);
          do_get(ID_FIRST);
          do_get(16'(RECORDS + 1));
          do_get(16'd1);
        end
      end
      idle_on = (i / PHASE_LEN < 4);
      random_request(i / PHASE_LEN);
    end
    drain_results();
    repeat (8) @(posedge clk_i);

    $display("covered %0d requests: %0d adds, %0d gets, %0d reserves, %0d erases",
             n_add + n_get + n_rsv + n_erase, n_add, n_get, n_rsv, n_erase);
    $display("%0d result words compared, %0d mismatches", compared, mismatches);
    if (mismatches == 0 && awaited == 0) begin
      $display("tb_event_log_ring_store passed");
    end else begin
      $display("tb_event_log_ring_store failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("tb_event_log_ring_store failed");
    $finish;
  end

endmodule
